FILE: rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// soft timer bank package
// shared constants, op codes, entry layout, per-entry tick function and run-time counter step
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PTR_W      = $clog2(NUM_TIMERS + 1);
    localparam int CNT_W      = 31;

    localparam logic [CNT_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_START_ONCE = 3'd1;
    localparam logic [2:0] OP_START_AUTO = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    typedef struct packed {
        logic [31:0] remaining;
        logic [31:0] reload;
        logic        flag;
        logic        auto_rl;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one tick applied to one timer entry
    function automatic entry_t tick_entry(input entry_t e);
        entry_t      r;
        logic [31:0] dec;
        r   = e;
        dec = e.remaining - 32'd1;
        if (e.remaining != 32'd0)
        begin
            r.remaining = dec;
            if (dec == 32'd0)
            begin
                r.flag = 1'b1;
                if (e.auto_rl)
                begin
                    r.remaining = e.reload;
                end
            end
        end
        return r;
    endfunction

    // run-time counter step, never holds the wrap value
    function automatic logic [CNT_W-1:0] run_step(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = c + CNT_W'(1);
        if (n == RUN_WRAP)
        begin
            n = '0;
        end
        return n;
    endfunction

endpackage

FILE: rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb ram
// generic single-write single-read synchronous memory, registered read data
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 66
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb control
// command sequencer: tick sweep and single-entry read-modify-write, entry
// valid bits, run-time counter and result registers
// ----------------------------------------------------------------------------
module stb_ctrl
    import stb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic [7:0]         timer_id,
    input  logic [31:0]        period,
    output logic               done,
    output logic               expired,
    output logic               id_error,
    output logic [CNT_W-1:0]   run_time,
    output logic               mem_we,
    output logic [IDX_W-1:0]   mem_waddr,
    output logic [ENTRY_W-1:0] mem_wdata,
    output logic               mem_re,
    output logic [IDX_W-1:0]   mem_raddr,
    input  logic [ENTRY_W-1:0] mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_SWEEP = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg;
    logic [IDX_W-1:0]   id_reg;
    logic [31:0]        period_reg;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic               wb_vld_reg, wb_vld_next;
    logic [IDX_W-1:0]   wb_idx_reg, wb_idx_next;
    logic               rd_vld_reg;
    logic [NUM_TIMERS-1:0] ent_valid_reg;
    logic [CNT_W-1:0]   run_cnt_reg, run_cnt_next;
    logic               done_reg, done_next;
    logic               expired_reg, expired_next;
    logic               id_error_reg, id_error_next;

    logic               accept;
    logic               id_ok;
    logic               is_id_op;
    entry_t             rd_ent;
    entry_t             wr_ent;

    assign accept   = start && (state_reg == ST_IDLE);
    assign id_ok    = ({1'b0, timer_id} < 9'(NUM_TIMERS));
    assign is_id_op = (op inside {OP_START_ONCE, OP_START_AUTO, OP_STOP, OP_CHECK});

    // entries never written read as the reset value
    assign rd_ent = rd_vld_reg ? entry_t'(mem_rdata) : '0;

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        wb_vld_next   = 1'b0;
        wb_idx_next   = wb_idx_reg;
        run_cnt_next  = run_cnt_reg;
        done_next     = 1'b0;
        expired_next  = 1'b0;
        id_error_next = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = id_reg;
        mem_we        = 1'b0;
        mem_waddr     = id_reg;
        wr_ent        = rd_ent;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_TICK)
                    begin
                        ptr_next   = '0;
                        state_next = ST_SWEEP;
                    end
                    else if (is_id_op && id_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        id_error_next = is_id_op;
                    end
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                case (op_reg)
                    OP_START_ONCE, OP_START_AUTO:
                    begin
                        wr_ent.remaining = period_reg;
                        wr_ent.reload    = period_reg;
                        wr_ent.flag      = 1'b0;
                        wr_ent.auto_rl   = (op_reg == OP_START_AUTO);
                    end
                    OP_STOP:
                    begin
                        wr_ent.remaining = '0;
                        wr_ent.flag      = 1'b0;
                        wr_ent.auto_rl   = 1'b0;
                    end
                    default:
                    begin
                        wr_ent.flag  = 1'b0;
                        expired_next = rd_ent.flag;
                    end
                endcase
                mem_we     = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                mem_raddr = ptr_reg[IDX_W-1:0];
                if (ptr_reg < PTR_W'(NUM_TIMERS))
                begin
                    mem_re      = 1'b1;
                    wb_vld_next = 1'b1;
                    wb_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next    = ptr_reg + PTR_W'(1);
                end
                if (wb_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wb_idx_reg;
                    wr_ent    = tick_entry(rd_ent);
                end
                if (ptr_reg == PTR_W'(NUM_TIMERS))
                begin
                    run_cnt_next = run_step(run_cnt_reg);
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_wdata = ENTRY_W'(wr_ent);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            wb_vld_reg    <= 1'b0;
            ent_valid_reg <= '0;
            run_cnt_reg   <= '0;
            done_reg      <= 1'b0;
            expired_reg   <= 1'b0;
            id_error_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            wb_vld_reg   <= wb_vld_next;
            run_cnt_reg  <= run_cnt_next;
            done_reg     <= done_next;
            expired_reg  <= expired_next;
            id_error_reg <= id_error_next;
            if (mem_we)
            begin
                ent_valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wb_idx_reg <= wb_idx_next;
        if (mem_re)
        begin
            rd_vld_reg <= ent_valid_reg[mem_raddr];
        end
        if (accept)
        begin
            op_reg     <= op;
            id_reg     <= timer_id[IDX_W-1:0];
            period_reg <= period;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign expired  = expired_reg;
    assign id_error = id_error_reg;
    assign run_time = run_cnt_reg;

endmodule

FILE: rtl/soft_timer_bank_top.sv
// ----------------------------------------------------------------------------
// soft timer bank top
// tick: done strobes after a sweep of all NUM_TIMERS entries, one entry per cycle
// through the single timer memory read and write ports
// start, stop, check: done strobes after the read and the write back
// unused op or out-of-range id: done strobes in the cycle after the transfer
// a new transfer is taken in the done cycle; reset clears entry valid bits at once
// ----------------------------------------------------------------------------
module soft_timer_bank_top
    import stb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       op,
    input  logic [7:0]       timer_id,
    input  logic [31:0]      period,
    output logic             done,
    output logic             expired,
    output logic             id_error,
    output logic [CNT_W-1:0] run_time
);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    stb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .timer_id  (timer_id),
        .period    (period),
        .done      (done),
        .expired   (expired),
        .id_error  (id_error),
        .run_time  (run_time),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    stb_ram #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/stb_checker.sv
// ----------------------------------------------------------------------------
// stb checker
// port-level checks on the soft timer bank, bound to the top level
// ----------------------------------------------------------------------------
module stb_checker
    import stb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [2:0]       op,
    input logic             done,
    input logic             expired,
    input logic             id_error,
    input logic [CNT_W-1:0] run_time
);

    // result strobe only once the block is free again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a tick transfer always starts a sweep
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_TICK)) |=> busy)
        else $error("tick not swept");

    // flags only show with a result
    a_flags_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (expired || id_error) |-> done)
        else $error("flag without done");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(expired && id_error))
        else $error("expired and id_error together");

    // run time moves only with a result transfer
    a_run_time_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(run_time) |-> done)
        else $error("run time changed without done");

endmodule

bind soft_timer_bank_top stb_checker u_stb_checker (.*);
